### sv/tpc_pkg.sv
// shared constants, payload types and memory request types for the trie prefix counter
package tpc_pkg;

  localparam int NODE_COUNT = 65536;
  localparam int ALPHABET   = 26;
  localparam int LETTER_W   = 5;
  localparam int CNT_W      = 32;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int SYM_W      = $clog2(ALPHABET);
  localparam int SLOT_DEPTH = NODE_COUNT * ALPHABET;
  localparam int SLOT_W     = $clog2(SLOT_DEPTH);

  // one input item
  typedef struct packed {
    logic                kind;
    logic [LETTER_W-1:0] letter;
    logic                last;
  } item_t;

  // one result item
  typedef struct packed {
    logic             was_query;
    logic [CNT_W-1:0] prefix_count;
    logic             status;
  } result_t;

  // node memory word: the slot that created the node, and its count
  typedef struct packed {
    logic [SLOT_W-1:0] parent;
    logic [CNT_W-1:0]  count;
  } node_word_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } child_req_t;

  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    node_word_t        wdata;
    logic              re;
    logic [NODE_W-1:0] raddr;
  } node_req_t;

  typedef struct packed {
    logic    valid;
    result_t data;
  } res_t;

endpackage

### sv/tpc_ram.sv
// generic single write port, single read port ram with registered read
module tpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/tpc_walk.sv
// walk sequencer: child lookup, node check, allocation and count update
module tpc_walk (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tpc_pkg::item_t      item,
  input  logic                out_free,
  output tpc_pkg::res_t       res,
  output tpc_pkg::child_req_t child_req,
  input  logic [tpc_pkg::NODE_W-1:0] child_rdata,
  output tpc_pkg::node_req_t  node_req,
  input  tpc_pkg::node_word_t node_rdata
);
  import tpc_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHILD = 2'd1;
  localparam logic [1:0] ST_NODE  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state, state_next;
  logic              cur_kind, cur_kind_next;
  logic              cur_last, cur_last_next;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [NODE_W-1:0] cand, cand_next;
  logic              cand_ok, cand_ok_next;
  logic [NODE_W-1:0] cursor, cursor_next;
  logic              path_missing, path_missing_next;
  logic              pool_exhausted, pool_exhausted_next;
  logic [FREE_W-1:0] next_free, next_free_next;
  logic [CNT_W-1:0]  hold_count, hold_count_next;

  logic              accept;
  logic              stopped;
  logic [SYM_W-1:0]  sym;
  logic [SLOT_W-1:0] in_slot;
  logic              hit;
  logic              pool_full;
  logic [CNT_W-1:0]  sat_count;
  logic [CNT_W-1:0]  walk_count;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign stopped    = path_missing || pool_exhausted;

  // clamp the letter and form the child table slot of the current node
  assign sym = (32'(item.letter) >= ALPHABET) ? SYM_W'(ALPHABET - 1) : SYM_W'(item.letter);
  assign in_slot = SLOT_W'(cursor) * SLOT_W'(ALPHABET) + SLOT_W'(sym);

  // the child is real only if its node was created from this very slot
  assign hit       = cand_ok && (node_rdata.parent == slot);
  assign pool_full = (next_free >= FREE_W'(NODE_COUNT));
  assign sat_count = (node_rdata.count == {CNT_W{1'b1}}) ? node_rdata.count
                                                         : node_rdata.count + 1'b1;

  // sequencer
  always_comb begin
    state_next          = state;
    cur_kind_next       = cur_kind;
    cur_last_next       = cur_last;
    slot_next           = slot;
    cand_next           = cand;
    cand_ok_next        = cand_ok;
    cursor_next         = cursor;
    path_missing_next   = path_missing;
    pool_exhausted_next = pool_exhausted;
    next_free_next      = next_free;
    hold_count_next     = hold_count;
    walk_count          = '0;

    res       = '0;
    child_req = '0;
    node_req  = '0;

    child_req.raddr = in_slot;
    node_req.raddr  = child_rdata;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          cur_kind_next = item.kind;
          cur_last_next = item.last;
          slot_next     = in_slot;
          if (!stopped) begin
            child_req.re = 1'b1;
            state_next   = ST_CHILD;
          end else if (item.last) begin
            state_next = ST_FIN;
          end
        end
      end

      ST_CHILD: begin
        cand_next    = child_rdata;
        cand_ok_next = (child_rdata != '0) && ({1'b0, child_rdata} < next_free);
        node_req.re  = 1'b1;
        state_next   = ST_NODE;
      end

      ST_NODE: begin
        if (hit) begin
          cursor_next = cand;
          if (!cur_kind) begin
            node_req.we           = 1'b1;
            node_req.waddr        = cand;
            node_req.wdata.parent = slot;
            node_req.wdata.count  = sat_count;
          end else begin
            // a query that found its child reports that node's count
            walk_count = node_rdata.count;
          end
        end else if (cur_kind) begin
          path_missing_next = 1'b1;
        end else if (pool_full) begin
          pool_exhausted_next = 1'b1;
        end else begin
          // allocate a fresh node for this slot
          child_req.we          = 1'b1;
          child_req.waddr       = slot;
          child_req.wdata       = next_free[NODE_W-1:0];
          node_req.we           = 1'b1;
          node_req.waddr        = next_free[NODE_W-1:0];
          node_req.wdata.parent = slot;
          node_req.wdata.count  = CNT_W'(1);
          cursor_next           = next_free[NODE_W-1:0];
          next_free_next        = next_free + 1'b1;
        end

        hold_count_next = walk_count;
        if (!cur_last) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          res.valid             = 1'b1;
          res.data.was_query    = cur_kind;
          res.data.prefix_count = walk_count;
          res.data.status       = !cur_kind && pool_exhausted_next;
          cursor_next           = '0;
          path_missing_next     = 1'b0;
          pool_exhausted_next   = 1'b0;
          state_next            = ST_IDLE;
        end else begin
          state_next = ST_FIN;
        end
      end

      ST_FIN: begin
        if (out_free) begin
          res.valid             = 1'b1;
          res.data.was_query    = cur_kind;
          res.data.prefix_count = (cur_kind && !stopped) ? hold_count : '0;
          res.data.status       = !cur_kind && pool_exhausted;
          cursor_next           = '0;
          path_missing_next     = 1'b0;
          pool_exhausted_next   = 1'b0;
          state_next            = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      cursor         <= '0;
      path_missing   <= 1'b0;
      pool_exhausted <= 1'b0;
      next_free      <= FREE_W'(1);
    end else begin
      state          <= state_next;
      cursor         <= cursor_next;
      path_missing   <= path_missing_next;
      pool_exhausted <= pool_exhausted_next;
      next_free      <= next_free_next;
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    cur_kind   <= cur_kind_next;
    cur_last   <= cur_last_next;
    slot       <= slot_next;
    cand       <= cand_next;
    cand_ok    <= cand_ok_next;
    hold_count <= hold_count_next;
  end

`ifndef SYNTHESIS
  // the free pointer never runs past the pool
  assert property (@(posedge clk) disable iff (rst) next_free <= FREE_W'(NODE_COUNT))
    else $error("free pointer beyond node pool");

  // the walk only ever sits on a node that has been handed out
  assert property (@(posedge clk) disable iff (rst) {1'b0, cursor} < next_free)
    else $error("cursor on unallocated node");

  // a walk stops for one reason only
  assert property (@(posedge clk) disable iff (rst) !(path_missing && pool_exhausted))
    else $error("both stop flags set");

  // every child table write hands out exactly one node
  assert property (@(posedge clk) disable iff (rst)
    child_req.we |=> next_free == $past(next_free) + 1'b1)
    else $error("allocation did not advance free pointer");

  // a result is only offered while the output register can take it
  assert property (@(posedge clk) disable iff (rst) res.valid |-> out_free)
    else $error("result offered to busy output");
`endif

endmodule

### sv/trie_prefix_counter_top.sv
// Trie prefix counter: one letter per transfer. A walked letter steps through child table
// read, node table read and write back; a letter of a word whose walk already stopped is
// only accepted, and for its last letter the result is then offered. A result leaves from the
// output register in the cycle after the last letter's final step; the next letter is taken while it waits.
// Synchronous active-high reset: root cursor, free pointer one, empty trie at once;
// no clearing pass, node entries are trusted only below the free pointer.
module trie_prefix_counter_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tpc_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output tpc_pkg::result_t result
);
  import tpc_pkg::*;

  child_req_t        child_req;
  node_req_t         node_req;
  logic [NODE_W-1:0] child_rdata;
  node_word_t        node_rdata;
  res_t              res;
  logic              out_free;

  assign out_free = !result_valid || result_ready;

  tpc_walk u_walk (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .out_free    (out_free),
    .res         (res),
    .child_req   (child_req),
    .child_rdata (child_rdata),
    .node_req    (node_req),
    .node_rdata  (node_rdata)
  );

  // child table: one entry per node and letter
  tpc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SLOT_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .we    (child_req.we),
    .waddr (child_req.waddr),
    .wdata (child_req.wdata),
    .re    (child_req.re),
    .raddr (child_req.raddr),
    .rdata (child_rdata)
  );

  // node table: creating slot and prefix count per node
  tpc_ram #(
    .WIDTH ($bits(node_word_t)),
    .DEPTH (NODE_COUNT)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_req.we),
    .waddr (node_req.waddr),
    .wdata (node_req.wdata),
    .re    (node_req.re),
    .raddr (node_req.raddr),
    .rdata (node_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res.valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      result <= res.data;
    end
  end

endmodule

### tb/sv/trie_prefix_counter_top_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the trie prefix counter: trie predictor, scoreboard, drivers
module trie_prefix_counter_top_tb;
  import tpc_pkg::*;

  localparam logic KIND_INSERT      = 1'b0;
  localparam logic KIND_QUERY       = 1'b1;
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_POOL_FULL = 1'b1;
  localparam int   MAX_LETTER       = 2**LETTER_W - 1;
  localparam int   REPORT_LIMIT     = 10;
  localparam int   HOLD_CYCLES      = 400;
  localparam int   PHASE_ITEMS      = 175;

  // trie predictor and store of expected prefix counts
  class trie_scoreboard;
    bit [NODE_W-1:0] child_of [int unsigned];
    bit [CNT_W-1:0]  word_tally [NODE_COUNT];
    int unsigned     next_node = 1;
    int unsigned     cursor = 0;
    bit              walk_lost = 1'b0;
    bit              pool_dry = 1'b0;
    result_t         outcome_q[$];
    int              errors = 0;

    // walk the trie for one accepted letter transfer
    function void note_item(item_t it);
      int unsigned sym;
      int unsigned slot;
      int unsigned child;
      result_t     want;
      sym = it.letter;
      if (sym >= ALPHABET) sym = ALPHABET - 1;
      if (!walk_lost && !pool_dry) begin
        slot  = cursor * ALPHABET + sym;
        child = child_of.exists(slot) ? child_of[slot] : 0;
        if (it.kind == KIND_QUERY) begin
          if (child == 0) walk_lost = 1'b1;
          else cursor = child;
        end else begin
          if (child == 0) begin
            if (next_node >= NODE_COUNT) begin
              pool_dry = 1'b1;
            end else begin
              child = next_node;
              child_of[slot] = child[NODE_W-1:0];
              next_node++;
            end
          end
          if (child != 0) begin
            cursor = child;
            if (word_tally[child] != {CNT_W{1'b1}}) word_tally[child]++;
          end
        end
      end
      // end of word: one result, then back to the root
      if (it.last) begin
        want.was_query = it.kind;
        if (it.kind == KIND_QUERY) begin
          want.prefix_count = (walk_lost || pool_dry) ? '0 : word_tally[cursor];
          want.status       = STATUS_OK;
        end else begin
          want.prefix_count = '0;
          want.status       = pool_dry ? STATUS_POOL_FULL : STATUS_OK;
        end
        outcome_q.push_back(want);
        cursor    = 0;
        walk_lost = 1'b0;
        pool_dry  = 1'b0;
      end
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (outcome_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: was_query=%0d prefix_count=%0d status=%0d",
                   got.was_query, got.prefix_count, got.status);
      end else begin
        want = outcome_q.pop_front();
        if (got.was_query !== want.was_query || got.prefix_count !== want.prefix_count ||
            got.status !== want.status) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("mismatch: expected was_query=%0d prefix_count=%0d status=%0d, got %0d %0d %0d",
                     want.was_query, want.prefix_count, want.status,
                     got.was_query, got.prefix_count, got.status);
        end
      end
    endfunction
  endclass

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  trie_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;

  trie_prefix_counter_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // result side: check each transfer, then pick ready for the next edge
  initial begin
    forever begin
      @(posedge clk);
      if (result_valid && result_ready) sb.check_result(result);
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // offer one letter, with random idle cycles ahead of it
  task automatic send_item(logic kind, int letter, logic last);
    item_t it;
    it.kind   = kind;
    it.letter = letter[LETTER_W-1:0];
    it.last   = last;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_item(it);
    items_sent++;
  endtask

  // one word or prefix; some letters may flip kind, a few go out of range
  task automatic send_word(logic kind, int len, int alpha_hi, int mix_pct);
    logic k;
    int   l;
    for (int i = 0; i < len; i++) begin
      k = ($urandom_range(99) < mix_pct) ? ~kind : kind;
      l = ($urandom_range(19) == 0) ? $urandom_range(MAX_LETTER) : $urandom_range(alpha_hi);
      send_item(k, l, i == len - 1);
    end
  endtask

  // mostly short words over a few letters so queries hit stored prefixes
  task automatic random_words(int n);
    int stop_at;
    int len;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(12, 1) : $urandom_range(4, 1);
      send_word(1'($urandom_range(1)), len, ($urandom_range(4) == 0) ? MAX_LETTER : 3,
                ($urandom_range(9) == 0) ? 50 : 0);
    end
  endtask

  initial begin
    int idle_tab [4] = '{0, 84, 0, 34};
    int stall_tab[4] = '{0, 0, 84, 34};
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: basic insert and query
    send_item(KIND_INSERT, 0, 1'b1);
    send_item(KIND_QUERY, 0, 1'b1);
    // out-of-range letters clamp to the last letter
    send_item(KIND_INSERT, MAX_LETTER, 1'b0);
    send_item(KIND_INSERT, ALPHABET - 1, 1'b1);
    send_item(KIND_QUERY, ALPHABET - 1, 1'b0);
    send_item(KIND_QUERY, MAX_LETTER, 1'b1);
    send_item(KIND_QUERY, 30, 1'b1);
    // missing path, and letters after the walk stopped
    send_item(KIND_QUERY, 5, 1'b1);
    send_item(KIND_QUERY, 7, 1'b0);
    send_item(KIND_QUERY, 0, 1'b1);
    send_item(KIND_INSERT, 0, 1'b0);
    send_item(KIND_INSERT, 16, 1'b1);
    send_item(KIND_QUERY, 0, 1'b1);
    // mixed kinds within one word
    send_item(KIND_INSERT, 0, 1'b0);
    send_item(KIND_QUERY, 16, 1'b1);
    send_item(KIND_QUERY, 0, 1'b0);
    send_item(KIND_INSERT, 8, 1'b1);
    send_item(KIND_INSERT, 15, 1'b1);
    send_item(KIND_QUERY, 15, 1'b1);

    // random phases; the first one starts with a long receiver hold-off
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      if (p == 0) hold_left = HOLD_CYCLES;
      random_words(PHASE_ITEMS);
    end

    // existing paths and new out-of-range paths, then queries over them
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(KIND_INSERT, 0, 1'b1);
    send_item(KIND_QUERY, 0, 1'b1);
    send_item(KIND_INSERT, 0, 1'b0);
    send_item(KIND_INSERT, 30, 1'b0);
    send_item(KIND_INSERT, 29, 1'b0);
    send_item(KIND_INSERT, 28, 1'b0);
    send_item(KIND_INSERT, 27, 1'b1);
    send_item(KIND_QUERY, 0, 1'b1);
    send_item(KIND_QUERY, 0, 1'b0);
    send_item(KIND_INSERT, 21, 1'b1);
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    random_words(40);
    item_valid <= 1'b0;

    // drain
    recv_stall_pct = 0;
    while (sb.outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.outcome_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/tpc_pkg.sv
sv/tpc_ram.sv
sv/tpc_walk.sv
sv/trie_prefix_counter_top.sv
tb/sv/trie_prefix_counter_top_tb.sv
